// File: hw/rtl/quaternion_point_rotate_core_macros.svh
// Assertion macros shared by the rotation core.
`ifndef QUATERNION_POINT_ROTATE_CORE_MACROS_SVH
`define QUATERNION_POINT_ROTATE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every edge out of reset.
`define QPR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: always");

// Antecedent implies consequent in the same cycle.
`define QPR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define QPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define QPR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define QPR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define QPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/qpr_pkg.sv
package qpr_pkg;

    // Payload widths
    localparam int PT_W  = 32;   // Q16.16 coordinate
    localparam int QT_W  = 16;   // Q2.14 quaternion component
    localparam int OUT_W = 32;

    // Internal widths
    localparam int QP_W      = 2 * QT_W;          // quaternion component product
    localparam int ENT_W     = QP_W + 1;          // matrix entry, scaled by 2^27
    localparam int HALF_W    = PT_W / 2;          // coordinate split point
    localparam int HI_PROD_W = HALF_W + ENT_W;    // signed upper half times entry
    localparam int LO_PROD_W = HALF_W + 1 + ENT_W; // unsigned lower half times entry
    localparam int HI_SUM_W  = HI_PROD_W + 2;
    localparam int LO_SUM_W  = LO_PROD_W + 2;
    localparam int ACC_W     = HI_SUM_W + HALF_W + 1;
    localparam int FRAC_SH   = 27;
    localparam int RES_W     = ACC_W - FRAC_SH;

    localparam int N_AXES = 3;
    localparam int STAGES = 6;

    localparam logic signed [ENT_W-1:0] ONE_ENT  = ENT_W'(64'd1 << FRAC_SH);
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'd1 << (FRAC_SH - 1));
    localparam logic signed [OUT_W-1:0] OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// File: hw/rtl/qpr_if.sv
interface qpr_point_if
    import qpr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    logic signed [QT_W-1:0] quat_w;
    logic signed [QT_W-1:0] quat_x;
    logic signed [QT_W-1:0] quat_y;
    logic signed [QT_W-1:0] quat_z;

    modport source (
        output valid, point_x, point_y, point_z, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

interface qpr_rot_if
    import qpr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] rotated_x;
    logic signed [OUT_W-1:0] rotated_y;
    logic signed [OUT_W-1:0] rotated_z;
    logic                    saturated;

    modport source (
        output valid, rotated_x, rotated_y, rotated_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y, rotated_z, saturated,
        output ready
    );
endinterface

// File: hw/rtl/quaternion_point_rotate_core.sv
// Channel    Dir  Payload                                   Transfer
// i_point    in   point_x/y/z Q16.16, quat_w/x/y/z Q2.14    valid & ready
// o_rot      out  rotated_x/y/z Q16.16, saturated          valid & ready
//
// Six register stages: quaternion products, matrix entries, split multiplies,
// row sums, rounding add, shift and saturate into the output register.
// One point per cycle sustained while o_rot is not stalled; each point passes the stages in order.
// Reset is synchronous and clears only the stage valid bits.
// A stall on o_rot freezes every stage together; i_point.ready drops only
// while the output register holds a result that is not being taken.
`include "quaternion_point_rotate_core_macros.svh"

module quaternion_point_rotate_core
    import qpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    qpr_point_if.sink  i_point,
    qpr_rot_if.source  o_rot
);

    logic              adv;
    logic [STAGES-1:0] r_vld;

    // stage 1: component products and the point
    logic signed [PT_W-1:0] r_s1_p [N_AXES];
    logic signed [QP_W-1:0] r_s1_xx, r_s1_yy, r_s1_zz, r_s1_xy, r_s1_xz;
    logic signed [QP_W-1:0] r_s1_yz, r_s1_wx, r_s1_wy, r_s1_wz;

    // stage 2: matrix entries
    logic signed [PT_W-1:0]  r_s2_p [N_AXES];
    logic signed [ENT_W-1:0] r_s2_e [N_AXES][N_AXES];
    logic signed [ENT_W-1:0] n_s2_e [N_AXES][N_AXES];

    // stage 3: partial products
    logic signed [HI_PROD_W-1:0] r_s3_hi [N_AXES][N_AXES];
    logic signed [LO_PROD_W-1:0] r_s3_lo [N_AXES][N_AXES];
    logic signed [HI_PROD_W-1:0] n_s3_hi [N_AXES][N_AXES];
    logic signed [LO_PROD_W-1:0] n_s3_lo [N_AXES][N_AXES];

    // stage 4: row sums
    logic signed [HI_SUM_W-1:0] r_s4_hi [N_AXES];
    logic signed [LO_SUM_W-1:0] r_s4_lo [N_AXES];

    // stage 5: rounded accumulator
    logic signed [ACC_W-1:0] r_s5_acc [N_AXES];

    // stage 6: output register
    logic signed [OUT_W-1:0] r_s6_out [N_AXES];
    logic signed [OUT_W-1:0] n_s6_out [N_AXES];
    logic                    r_s6_sat;
    logic                    n_s6_sat;

    assign adv           = !r_vld[STAGES-1] || o_rot.ready;
    assign i_point.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_point.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_p[0] <= i_point.point_x;
            r_s1_p[1] <= i_point.point_y;
            r_s1_p[2] <= i_point.point_z;
            r_s1_xx   <= QP_W'(i_point.quat_x) * QP_W'(i_point.quat_x);
            r_s1_yy   <= QP_W'(i_point.quat_y) * QP_W'(i_point.quat_y);
            r_s1_zz   <= QP_W'(i_point.quat_z) * QP_W'(i_point.quat_z);
            r_s1_xy   <= QP_W'(i_point.quat_x) * QP_W'(i_point.quat_y);
            r_s1_xz   <= QP_W'(i_point.quat_x) * QP_W'(i_point.quat_z);
            r_s1_yz   <= QP_W'(i_point.quat_y) * QP_W'(i_point.quat_z);
            r_s1_wx   <= QP_W'(i_point.quat_w) * QP_W'(i_point.quat_x);
            r_s1_wy   <= QP_W'(i_point.quat_w) * QP_W'(i_point.quat_y);
            r_s1_wz   <= QP_W'(i_point.quat_w) * QP_W'(i_point.quat_z);
        end
    end

    // entries are the matrix scaled by 2^27
    always_comb begin
        n_s2_e[0][0] = ONE_ENT - ENT_W'(r_s1_yy) - ENT_W'(r_s1_zz);
        n_s2_e[0][1] = ENT_W'(r_s1_xy) - ENT_W'(r_s1_wz);
        n_s2_e[0][2] = ENT_W'(r_s1_xz) + ENT_W'(r_s1_wy);
        n_s2_e[1][0] = ENT_W'(r_s1_xy) + ENT_W'(r_s1_wz);
        n_s2_e[1][1] = ONE_ENT - ENT_W'(r_s1_xx) - ENT_W'(r_s1_zz);
        n_s2_e[1][2] = ENT_W'(r_s1_yz) - ENT_W'(r_s1_wx);
        n_s2_e[2][0] = ENT_W'(r_s1_xz) - ENT_W'(r_s1_wy);
        n_s2_e[2][1] = ENT_W'(r_s1_yz) + ENT_W'(r_s1_wx);
        n_s2_e[2][2] = ONE_ENT - ENT_W'(r_s1_xx) - ENT_W'(r_s1_yy);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_p <= r_s1_p;
            r_s2_e <= n_s2_e;
        end
    end

    // each coordinate split into a signed upper half and an unsigned lower half
    always_comb begin
        for (int r = 0; r < N_AXES; r++) begin
            for (int c = 0; c < N_AXES; c++) begin
                n_s3_hi[r][c] = HI_PROD_W'($signed(r_s2_p[c][PT_W-1:HALF_W]))
                              * HI_PROD_W'(r_s2_e[r][c]);
                n_s3_lo[r][c] = LO_PROD_W'($signed({1'b0, r_s2_p[c][HALF_W-1:0]}))
                              * LO_PROD_W'(r_s2_e[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_hi <= n_s3_hi;
            r_s3_lo <= n_s3_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < N_AXES; r++) begin
                r_s4_hi[r] <= HI_SUM_W'(r_s3_hi[r][0]) + HI_SUM_W'(r_s3_hi[r][1])
                            + HI_SUM_W'(r_s3_hi[r][2]);
                r_s4_lo[r] <= LO_SUM_W'(r_s3_lo[r][0]) + LO_SUM_W'(r_s3_lo[r][1])
                            + LO_SUM_W'(r_s3_lo[r][2]);
            end
        end
    end

    // exact dot product plus half an output step; ties go up
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < N_AXES; r++) begin
                r_s5_acc[r] <= (ACC_W'(r_s4_hi[r]) <<< HALF_W) + ACC_W'(r_s4_lo[r])
                             + RND_BIAS;
            end
        end
    end

    always_comb begin
        logic signed [RES_W-1:0] res;
        logic                    ovf;
        n_s6_sat = 1'b0;
        for (int r = 0; r < N_AXES; r++) begin
            res = r_s5_acc[r][ACC_W-1:FRAC_SH];
            // out of range when the bits above the result sign disagree with it
            ovf = !((&res[RES_W-1:OUT_W-1]) || !(|res[RES_W-1:OUT_W-1]));
            if (ovf) begin
                n_s6_out[r] = res[RES_W-1] ? OUT_MIN : OUT_MAX;
            end else begin
                n_s6_out[r] = res[OUT_W-1:0];
            end
            n_s6_sat = n_s6_sat | ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s6_out <= n_s6_out;
            r_s6_sat <= n_s6_sat;
        end
    end

    assign o_rot.valid     = r_vld[STAGES-1];
    assign o_rot.rotated_x = r_s6_out[0];
    assign o_rot.rotated_y = r_s6_out[1];
    assign o_rot.rotated_z = r_s6_out[2];
    assign o_rot.saturated = r_s6_sat;

    `QPR_ASSERT_IMPLIES(a_sat_clips, i_clk, i_rst_n, o_rot.valid && o_rot.saturated,
        o_rot.rotated_x == OUT_MAX || o_rot.rotated_x == OUT_MIN ||
        o_rot.rotated_y == OUT_MAX || o_rot.rotated_y == OUT_MIN ||
        o_rot.rotated_z == OUT_MAX || o_rot.rotated_z == OUT_MIN)
    `QPR_ASSERT_IMPLIES(a_stall_blocks_in, i_clk, i_rst_n, o_rot.valid && !o_rot.ready,
        !i_point.ready)
    `QPR_ASSERT_NEXT(a_in_enters, i_clk, i_rst_n, i_point.valid && i_point.ready, r_vld[0])

endmodule
